### rtl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared types and constants of the chunk stream packetizer.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int unsigned NUM_CHUNK_STREAMS_DEF = 32;
  localparam int unsigned ID_W                  = 5;
  localparam int unsigned CFG_IDX_W             = 1;
  localparam int unsigned CFG_DATA_W            = 32;

  localparam logic [15:0] CHUNK_SIZE_RST = 16'd128;
  localparam logic [7:0]  HDR_TYPE1      = 8'h40;
  localparam logic [7:0]  HDR_TYPE3      = 8'hC0;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_STREAM_ID = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CONT,
    KIND_TYPE1,
    KIND_TYPE0
  } hdr_kind_e;

  typedef struct packed {
    hdr_kind_e       kind;
    logic [ID_W-1:0] id;
    logic [7:0]      pay;
    logic            last;
    logic [31:0]     ts;
    logic [23:0]     len;
    logic [7:0]      typ;
  } rmc_item_t;

endpackage

### rtl/rmc_ts_ram.sv
// ----------------------------------------------------------------------------
// rmc_ts_ram
// Per-stream timestamp store, one port, read-first, registered read data.
// ----------------------------------------------------------------------------
module rmc_ts_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [31:0]   wdata_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rmc_framer.sv
// ----------------------------------------------------------------------------
// rmc_framer
// Expands one item into its header bytes and payload byte, output register.
// ----------------------------------------------------------------------------
module rmc_framer
  import rmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  rmc_item_t   item_i,
  input  logic [31:0] ts_prev_i,
  input  logic [31:0] msid_i,
  output logic        take_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        message_end_o
);

  localparam logic [3:0] LAST_NONE  = 4'd0;
  localparam logic [3:0] LAST_CONT  = 4'd1;
  localparam logic [3:0] LAST_TYPE1 = 4'd8;
  localparam logic [3:0] LAST_TYPE0 = 4'd12;

  logic        s1_valid_q;
  rmc_item_t   s1_q;
  logic [3:0]  cnt_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        run_last_q;
  logic        message_end_q;

  logic        out_free;
  logic        at_last;
  logic        s1_done;
  logic        take;
  logic [3:0]  last_cnt;
  logic [23:0] delta;
  logic [23:0] ts_sel;
  logic [7:0]  id_byte;
  logic [7:0]  byte_d;

  always_comb begin
    case (s1_q.kind)
      KIND_NONE:  last_cnt = LAST_NONE;
      KIND_CONT:  last_cnt = LAST_CONT;
      KIND_TYPE1: last_cnt = LAST_TYPE1;
      KIND_TYPE0: last_cnt = LAST_TYPE0;
      default:    last_cnt = LAST_NONE;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign at_last  = (cnt_q == last_cnt);
  assign s1_done  = s1_valid_q && out_free && at_last;
  assign take     = !s1_valid_q || s1_done;
  assign take_o   = take;

  assign delta  = 24'(s1_q.ts - ts_prev_i);
  assign ts_sel = (s1_q.kind == KIND_TYPE0) ? s1_q.ts[23:0] : delta;

  always_comb begin
    case (s1_q.kind)
      KIND_TYPE1: id_byte = HDR_TYPE1 | 8'(s1_q.id);
      KIND_CONT:  id_byte = HDR_TYPE3 | 8'(s1_q.id);
      default:    id_byte = 8'(s1_q.id);
    endcase
  end

  always_comb begin
    if (at_last) begin
      byte_d = s1_q.pay;
    end else begin
      case (cnt_q)
        4'd0:    byte_d = id_byte;
        4'd1:    byte_d = ts_sel[23:16];
        4'd2:    byte_d = ts_sel[15:8];
        4'd3:    byte_d = ts_sel[7:0];
        4'd4:    byte_d = s1_q.len[23:16];
        4'd5:    byte_d = s1_q.len[15:8];
        4'd6:    byte_d = s1_q.len[7:0];
        4'd7:    byte_d = s1_q.typ;
        4'd8:    byte_d = msid_i[7:0];
        4'd9:    byte_d = msid_i[15:8];
        4'd10:   byte_d = msid_i[23:16];
        4'd11:   byte_d = msid_i[31:24];
        default: byte_d = s1_q.pay;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        s1_valid_q <= item_valid_i;
        cnt_q      <= '0;
      end else if (s1_valid_q && out_free) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= item_i;
    end
    if (out_free && s1_valid_q) begin
      out_byte_q    <= byte_d;
      run_last_q    <= at_last;
      message_end_q <= at_last && s1_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign message_end_o = message_end_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> cnt_q <= last_cnt)
    else $error("byte counter ran past the end of the item");

  a_take_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !s1_valid_q || (out_free && at_last))
    else $error("new item taken while the current one is still in flight");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_done && !item_valid_i |=> !s1_valid_q)
    else $error("stage stayed busy after its last byte left");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && message_end_q |-> run_last_q)
    else $error("message end flagged on a header byte");

endmodule

### rtl/rtmp_message_chunker.sv
// ----------------------------------------------------------------------------
// rtmp_message_chunker
// Splits an outgoing message into chunks with type-0/1/3 headers.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the framer's item stage, and each of its bytes
//   then passes through the single output register; one output byte per cycle
//   while out_stall_i is low. A plain payload byte goes out alone, with a
//   continuation header as 2 bytes, a type-1 message start 9, a type-0 one 13.
// Reset: stream-seen flags clear at once; the timestamp memory is not cleared
//   and its read data is only used for streams already seen. chunk_size resets to 128.
module rtmp_message_chunker
  import rmc_pkg::*;
#(
  parameter int unsigned NUM_CHUNK_STREAMS = NUM_CHUNK_STREAMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            payload_byte_i,
  input  logic                  first_byte_i,
  input  logic                  last_byte_i,
  input  logic [ID_W-1:0]       chunk_stream_i,
  input  logic [31:0]           msg_timestamp_i,
  input  logic [23:0]           msg_len_i,
  input  logic [7:0]            msg_type_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_last_o,
  output logic                  message_end_o
);

  localparam int unsigned IW = $clog2(NUM_CHUNK_STREAMS);

  logic [15:0]                  chunk_size_q;
  logic [31:0]                  msid_q;
  logic [15:0]                  bic_q, bic_d;
  logic [ID_W-1:0]              cur_q;
  logic [NUM_CHUNK_STREAMS-1:0] seen_q;

  logic        take;
  logic        accept;
  logic        need_cont;
  logic [IW-1:0] idx;
  rmc_item_t   item;
  logic [31:0] ts_prev;

  always_comb begin
    idx = '0;
    for (int k = 0; k < (1 << ID_W); k++) begin
      if (chunk_stream_i == ID_W'(k)) begin
        idx = IW'(k % NUM_CHUNK_STREAMS);
      end
    end
  end

  assign accept     = in_valid_i && take;
  assign in_stall_o = !take;
  assign need_cont  = (bic_q >= chunk_size_q);

  always_comb begin
    item.pay  = payload_byte_i;
    item.last = last_byte_i;
    item.ts   = msg_timestamp_i;
    item.len  = msg_len_i;
    item.typ  = msg_type_i;
    if (first_byte_i) begin
      item.kind = seen_q[idx] ? KIND_TYPE1 : KIND_TYPE0;
      item.id   = chunk_stream_i;
      bic_d     = 16'd1;
    end else begin
      item.kind = need_cont ? KIND_CONT : KIND_NONE;
      item.id   = cur_q;
      bic_d     = need_cont ? 16'd1 : bic_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= CHUNK_SIZE_RST;
      msid_q       <= '0;
      bic_q        <= '0;
      cur_q        <= '0;
      seen_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHUNK_SIZE:    chunk_size_q <= cfg_data_i[15:0];
          CFG_MSG_STREAM_ID: msid_q       <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        bic_q <= bic_d;
        if (first_byte_i) begin
          cur_q       <= chunk_stream_i;
          seen_q[idx] <= 1'b1;
        end
      end
    end
  end

  rmc_ts_ram #(
    .DEPTH (NUM_CHUNK_STREAMS),
    .AW    (IW)
  ) u_ts_ram (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (first_byte_i),
    .addr_i  (idx),
    .wdata_i (msg_timestamp_i),
    .rdata_o (ts_prev)
  );

  rmc_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (in_valid_i),
    .item_i        (item),
    .ts_prev_i     (ts_prev),
    .msid_i        (msid_q),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule

### tb/sv/rmc_checker.sv
// ----------------------------------------------------------------------------
// rmc_checker
// Watches both channels and the register port of the chunk stream
// packetizer. It predicts the chunked byte stream for every input transfer
// and compares each output transfer, field by field, with the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module rmc_checker
  import rmc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [7:0]            payload_byte_i,
  input  logic                  first_byte_i,
  input  logic                  last_byte_i,
  input  logic [ID_W-1:0]       chunk_stream_i,
  input  logic [31:0]           msg_timestamp_i,
  input  logic [23:0]           msg_len_i,
  input  logic [7:0]            msg_type_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            out_byte_i,
  input  logic                  run_last_i,
  input  logic                  message_end_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       msg_end;
  } chunk_byte_t;

  chunk_byte_t     chunked_bytes_q[$];
  logic [31:0]     ts_table[NUM_CHUNK_STREAMS_DEF];
  logic            stream_seen[NUM_CHUNK_STREAMS_DEF];
  logic [15:0]     chunk_fill;
  logic [ID_W-1:0] active_stream;
  logic [15:0]     chunk_size_q;
  logic [31:0]     msg_stream_id_q;

  initial fail_count_o = 0;

  task automatic push_byte(input logic [7:0] data, input logic run_last,
                           input logic msg_end);
    chunk_byte_t b;
    b.data     = data;
    b.run_last = run_last;
    b.msg_end  = msg_end;
    chunked_bytes_q.push_back(b);
  endtask

  task automatic push_be24(input logic [23:0] v);
    push_byte(v[23:16], 1'b0, 1'b0);
    push_byte(v[15:8], 1'b0, 1'b0);
    push_byte(v[7:0], 1'b0, 1'b0);
  endtask

  task automatic chunk_payload_byte(input logic [7:0] pay, input logic first,
                                    input logic last, input logic [ID_W-1:0] cs,
                                    input logic [31:0] ts, input logic [23:0] len,
                                    input logic [7:0] typ);
    logic [31:0] delta;
    int unsigned slot;
    slot = cs % NUM_CHUNK_STREAMS_DEF;
    if (first) begin
      active_stream = cs;
      if (!stream_seen[slot]) begin
        push_byte({3'b000, cs}, 1'b0, 1'b0);
        push_be24(ts[23:0]);
        push_be24(len);
        push_byte(typ, 1'b0, 1'b0);
        push_byte(msg_stream_id_q[7:0], 1'b0, 1'b0);
        push_byte(msg_stream_id_q[15:8], 1'b0, 1'b0);
        push_byte(msg_stream_id_q[23:16], 1'b0, 1'b0);
        push_byte(msg_stream_id_q[31:24], 1'b0, 1'b0);
      end else begin
        delta = ts - ts_table[slot];
        push_byte(HDR_TYPE1 | {3'b000, cs}, 1'b0, 1'b0);
        push_be24(delta[23:0]);
        push_be24(len);
        push_byte(typ, 1'b0, 1'b0);
      end
      stream_seen[slot] = 1'b1;
      ts_table[slot]    = ts;
      chunk_fill        = 16'd1;
    end else if (chunk_fill >= chunk_size_q) begin
      push_byte(HDR_TYPE3 | {3'b000, active_stream}, 1'b0, 1'b0);
      chunk_fill = 16'd1;
    end else begin
      chunk_fill = chunk_fill + 16'd1;
    end
    push_byte(pay, 1'b1, last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    chunk_byte_t exp;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHUNK_STREAMS_DEF; i++) stream_seen[i] = 1'b0;
      chunk_fill      = '0;
      active_stream   = '0;
      chunk_size_q    = CHUNK_SIZE_RST;
      msg_stream_id_q = '0;
      chunked_bytes_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (chunked_bytes_q.size() == 0) begin
          $error("unexpected output transfer: out_byte actual %02h", out_byte_i);
          fail_count_o++;
        end else begin
          exp = chunked_bytes_q.pop_front();
          if (out_byte_i !== exp.data) begin
            $error("out_byte: expected %02h, actual %02h", exp.data, out_byte_i);
            fail_count_o++;
          end
          if (run_last_i !== exp.run_last) begin
            $error("run_last: expected %0b, actual %0b", exp.run_last, run_last_i);
            fail_count_o++;
          end
          if (message_end_i !== exp.msg_end) begin
            $error("message_end: expected %0b, actual %0b", exp.msg_end, message_end_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHUNK_SIZE:    chunk_size_q = cfg_data_i[15:0];
          CFG_MSG_STREAM_ID: msg_stream_id_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        chunk_payload_byte(payload_byte_i, first_byte_i, last_byte_i, chunk_stream_i,
                           msg_timestamp_i, msg_len_i, msg_type_i);
      pending_o <= chunked_bytes_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the chunk stream packetizer with directed messages and then random
// message traffic over several register settings and idle/stall profiles.
// A checker beside the block predicts and compares the output stream.
// ----------------------------------------------------------------------------
module testbench;
  import rmc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 40;
  localparam int NUM_PHASES   = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            payload_byte;
  logic                  first_byte;
  logic                  last_byte;
  logic [ID_W-1:0]       chunk_stream;
  logic [31:0]           msg_timestamp;
  logic [23:0]           msg_len;
  logic [7:0]            msg_type;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  run_last;
  logic                  message_end;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int items_sent  = 0;

  rtmp_message_chunker u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .payload_byte_i  (payload_byte),
    .first_byte_i    (first_byte),
    .last_byte_i     (last_byte),
    .chunk_stream_i  (chunk_stream),
    .msg_timestamp_i (msg_timestamp),
    .msg_len_i       (msg_len),
    .msg_type_i      (msg_type),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_byte_o      (out_byte),
    .run_last_o      (run_last),
    .message_end_o   (message_end)
  );

  rmc_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .payload_byte_i  (payload_byte),
    .first_byte_i    (first_byte),
    .last_byte_i     (last_byte),
    .chunk_stream_i  (chunk_stream),
    .msg_timestamp_i (msg_timestamp),
    .msg_len_i       (msg_len),
    .msg_type_i      (msg_type),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_byte_i      (out_byte),
    .run_last_i      (run_last),
    .message_end_i   (message_end),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] pay, input logic first, input logic last,
                           input logic [ID_W-1:0] cs, input logic [31:0] ts,
                           input logic [23:0] len, input logic [7:0] typ);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    payload_byte  <= pay;
    first_byte    <= first;
    last_byte     <= last;
    chunk_stream  <= cs;
    msg_timestamp <= ts;
    msg_len       <= len;
    msg_type      <= typ;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_message(input logic [ID_W-1:0] cs, input logic [31:0] ts,
                              input logic [23:0] len, input logic [7:0] typ,
                              input int n, input bit close);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), i == 0, close && (i == n - 1), cs, ts, len, typ);
  endtask

  // stop sending and wait until every predicted byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int chunk_sizes[NUM_PHASES];
    logic [31:0] stream_ids[NUM_PHASES];
    int r;
    int n;
    logic [ID_W-1:0] cs;

    chunk_sizes = '{1, 4, 65535, 0, 3, 2};
    stream_ids  = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0001, 32'h0, 32'h1234_5678, 32'h0};
    stream_ids[4] = $urandom;
    chunk_sizes[4] = $urandom_range(2, 16);

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_CHUNK_SIZE;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    payload_byte  <= '0;
    first_byte    <= 1'b0;
    last_byte     <= 1'b0;
    chunk_stream  <= '0;
    msg_timestamp <= '0;
    msg_len       <= '0;
    msg_type      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray bytes right after reset, no message open
    send_byte(8'h00, 1'b0, 1'b0, ID_W'($urandom), $urandom, 24'($urandom), 8'($urandom));
    send_byte(8'hFF, 1'b0, 1'b1, ID_W'($urandom), $urandom, 24'($urandom), 8'($urandom));
    drain();
    write_reg(CFG_CHUNK_SIZE, 32'd2);
    write_reg(CFG_MSG_STREAM_ID, 32'hFFFF_FFFF);

    // type-0 on stream 0 with all-ones header fields, continuation inside
    send_byte(8'hFF, 1'b1, 1'b0, 5'd0, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
    send_byte(8'h00, 1'b0, 1'b0, ID_W'($urandom), $urandom, 24'($urandom), 8'($urandom));
    send_byte(8'hA5, 1'b0, 1'b0, ID_W'($urandom), $urandom, 24'($urandom), 8'($urandom));
    send_byte(8'h5A, 1'b0, 1'b1, ID_W'($urandom), $urandom, 24'($urandom), 8'($urandom));
    // type-1 with wrapping delta, one-byte message, zero header fields
    send_byte(8'h3C, 1'b1, 1'b1, 5'd0, 32'h0, 24'h0, 8'h00);
    // stream 1, declared length does not match
    send_message(5'd1, 32'h00AB_CDEF, 24'd3, 8'h14, 1, 1'b1);
    send_message(5'd31, 32'h1234_5678, 24'd3, 8'h09, 3, 1'b1);
    send_message(5'd31, 32'h1234_5677, 24'd1, 8'h08, 1, 1'b1);
    // bytes after the message has ended keep counting on stream 31
    send_byte(8'($urandom), 1'b0, 1'b0, ID_W'($urandom), $urandom, 24'($urandom),
              8'($urandom));
    send_byte(8'($urandom), 1'b0, 1'b1, ID_W'($urandom), $urandom, 24'($urandom),
              8'($urandom));
    drain();
    write_reg(CFG_CHUNK_SIZE, 32'd0);
    write_reg(CFG_MSG_STREAM_ID, 32'd0);
    send_message(5'd5, $urandom, 24'd3, 8'h12, 3, 1'b1);
    send_message(5'd5, $urandom, 24'd2, 8'h12, 2, 1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_CHUNK_SIZE, chunk_sizes[p]);
      write_reg(CFG_MSG_STREAM_ID, stream_ids[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        r  = $urandom_range(99);
        cs = ID_W'($urandom);
        n  = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        if (r < 85) begin
          send_message(cs, $urandom, ($urandom_range(1) == 0) ? 24'(n) : 24'($urandom),
                       8'($urandom), n, 1'b1);
        end else if (r < 93) begin
          send_byte(8'($urandom), 1'($urandom_range(1)), ID_W'($urandom) == '1 ? 1'b0 : 1'b0,
                    ID_W'($urandom), $urandom, 24'($urandom), 8'($urandom));
        end else begin
          // message cut off without its final byte
          send_message(cs, $urandom, 24'($urandom), 8'($urandom), n, 1'b0);
        end
        if ($urandom_range(29) == 0) drain();
      end
      drain();
    end
    stall_pct = 0;

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
